FILE: rtl/core/pfb_pkg.sv
// Shared types and constants for the packed frame store rectangle filler.
// Screen geometry, derived widths, command codes, store request and state types.
// No dependencies.
package pfb_pkg;

	localparam int SCREEN_WIDTH  = 640;
	localparam int SCREEN_HEIGHT = 480;

	localparam int PIX_TOTAL   = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int STORE_DEPTH = (PIX_TOTAL + 1) / 2;

	localparam int COL_W  = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
	localparam int ROW_W  = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
	localparam int PIX_W  = (PIX_TOTAL > 1) ? $clog2(PIX_TOTAL) : 1;
	localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	localparam int CRD_W = 11;
	localparam int EXT_W = 14;

	localparam logic [CRD_W-1:0] X_MAX = CRD_W'(SCREEN_WIDTH - 1);
	localparam logic [CRD_W-1:0] Y_MAX = CRD_W'(SCREEN_HEIGHT - 1);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

	localparam logic [1:0] CMD_DRAW  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef struct packed {
		logic              valid;
		logic              wr;
		logic [ADDR_W-1:0] addr;
		logic              odd;
		logic [2:0]        color;
	} req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_BASE,
		ST_DRAW,
		ST_READ,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/core/pfb_store.sv
// Frame store memory with pixel read-modify-write and same-entry forwarding.
// Holds two 3-bit pixels per entry; registered read, one write port.
// Depends on pfb_pkg.
module pfb_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pfb_pkg::req_t              req,
	input  logic                       clr_en,
	input  logic [pfb_pkg::ADDR_W-1:0] clr_addr,
	output logic [2:0]                 pix
);

	logic [5:0] mem [pfb_pkg::STORE_DEPTH];
	logic [5:0] rd_q;

	logic                       valid_s1;
	logic                       wr_s1;
	logic [pfb_pkg::ADDR_W-1:0] addr_s1;
	logic                       odd_s1;
	logic [2:0]                 color_s1;

	logic                       fwd_v_q;
	logic [pfb_pkg::ADDR_W-1:0] fwd_addr_q;
	logic [5:0]                 fwd_data_q;

	logic [5:0]                 cur;
	logic [5:0]                 merged;
	logic                       we;
	logic [pfb_pkg::ADDR_W-1:0] wa;
	logic [5:0]                 wd;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[req.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_v_q  <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
			fwd_v_q  <= we;
		end
	end

	always_ff @(posedge clk) begin
		wr_s1      <= req.wr;
		addr_s1    <= req.addr;
		odd_s1     <= req.odd;
		color_s1   <= req.color;
		fwd_addr_q <= wa;
		fwd_data_q <= wd;
	end

	// take the write that landed on the same edge as the read
	assign cur    = (fwd_v_q && fwd_addr_q == addr_s1) ? fwd_data_q : rd_q;
	assign merged = odd_s1 ? {color_s1, cur[2:0]} : {cur[5:3], color_s1};
	assign we     = clr_en | (valid_s1 & wr_s1);
	assign wa     = clr_en ? clr_addr : addr_s1;
	assign wd     = clr_en ? 6'd0 : merged;
	assign pix    = odd_s1 ? cur[5:3] : cur[2:0];

endmodule

FILE: rtl/core/packed_framebuffer_rect_fill.sv
// Drawing engine over a 640x480 frame store of 3-bit pixels packed two per entry.
// Depends on pfb_pkg and pfb_store.
//
// Input channel (in_valid/in_stall) takes one command beat: draw rectangle, read
// pixel or clear store. Output channel (out_valid/out_stall) returns one beat per
// command: the pixel color for a read, zero otherwise.
// Commands run one at a time; in_stall is high while a command is at work.
// Draw fills the rectangle clamped to the screen, one pixel per cycle through the
// store's read-modify-write path, and skips the store for a zero size; clear
// writes one entry a cycle through the single write port. in_stall drops as the
// result enters the output register.
// After reset the store is cleared the same way, with in_stall high. A result
// waits in the output register while out_stall is high; the next command is
// accepted meanwhile and holds in its last step until the output register frees.
module packed_framebuffer_rect_fill (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic signed [11:0] x_pos,
	input  logic signed [11:0] y_pos,
	input  logic [10:0]        rect_width,
	input  logic [10:0]        rect_height,
	input  logic [2:0]         draw_color,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         pixel_color
);

	pfb_pkg::state_t state_q, state_d;

	logic [1:0]         cmd_q;
	logic signed [11:0] x_q, y_q;
	logic [10:0]        w_q, h_q;
	logic [2:0]         color_q;

	logic [pfb_pkg::COL_W-1:0]  x0_q, x1_q, col_q;
	logic [pfb_pkg::ROW_W-1:0]  y0_q, y1_q, row_q;
	logic [pfb_pkg::PIX_W-1:0]  p_q, rbase_q, base;
	logic [pfb_pkg::ADDR_W-1:0] clr_cnt_q;
	logic                       clr_res_q;
	logic [2:0]                 res_q;
	logic                       out_valid_q;
	logic [2:0]                 out_pix_q;

	logic signed [pfb_pkg::EXT_W-1:0] xs, ys, xe, ye;
	logic                             in_acc, out_free, row_end, last_pix;
	pfb_pkg::req_t                    req;
	logic                             clr_en;
	logic [2:0]                       pix;

	function automatic logic [pfb_pkg::CRD_W-1:0] clamp_crd(
		input logic signed [pfb_pkg::EXT_W-1:0] v,
		input logic [pfb_pkg::CRD_W-1:0]        hi
	);
		logic signed [pfb_pkg::EXT_W-1:0] his;
		his = {{(pfb_pkg::EXT_W - pfb_pkg::CRD_W){1'b0}}, hi};
		if (v < 0) begin
			return '0;
		end else if (v > his) begin
			return hi;
		end
		return v[pfb_pkg::CRD_W-1:0];
	endfunction

	assign in_acc   = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;
	assign row_end  = (col_q == x1_q);
	assign last_pix = row_end && (row_q == y1_q);

	assign xs = {{2{x_q[11]}}, x_q};
	assign ys = {{2{y_q[11]}}, y_q};
	assign xe = xs + $signed({3'b000, w_q}) - 14'sd1;
	assign ye = ys + $signed({3'b000, h_q}) - 14'sd1;

	assign base = pfb_pkg::PIX_W'(y0_q) * pfb_pkg::PIX_W'(pfb_pkg::SCREEN_WIDTH)
		+ pfb_pkg::PIX_W'(x0_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfb_pkg::ST_CLEAR: begin
				if (clr_cnt_q == pfb_pkg::LAST_ADDR) begin
					state_d = clr_res_q ? pfb_pkg::ST_DONE : pfb_pkg::ST_IDLE;
				end
			end
			pfb_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = pfb_pkg::ST_SETUP;
				end
			end
			pfb_pkg::ST_SETUP: begin
				case (cmd_q)
					pfb_pkg::CMD_DRAW: begin
						state_d = (w_q == '0 || h_q == '0) ? pfb_pkg::ST_DONE
							: pfb_pkg::ST_BASE;
					end
					pfb_pkg::CMD_READ:  state_d = pfb_pkg::ST_BASE;
					pfb_pkg::CMD_CLEAR: state_d = pfb_pkg::ST_CLEAR;
					default:            state_d = pfb_pkg::ST_DONE;
				endcase
			end
			pfb_pkg::ST_BASE: begin
				state_d = (cmd_q == pfb_pkg::CMD_READ) ? pfb_pkg::ST_READ : pfb_pkg::ST_DRAW;
			end
			pfb_pkg::ST_DRAW: begin
				if (last_pix) begin
					state_d = pfb_pkg::ST_DRAIN;
				end
			end
			pfb_pkg::ST_READ:  state_d = pfb_pkg::ST_DRAIN;
			pfb_pkg::ST_DRAIN: state_d = pfb_pkg::ST_DONE;
			pfb_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = pfb_pkg::ST_IDLE;
				end
			end
			default: state_d = pfb_pkg::ST_IDLE;
		endcase
	end

	// outputs to the store and the input channel
	always_comb begin
		in_stall  = 1'b1;
		clr_en    = 1'b0;
		req.valid = 1'b0;
		req.wr    = 1'b0;
		req.addr  = pfb_pkg::ADDR_W'(p_q >> 1);
		req.odd   = p_q[0];
		req.color = color_q;
		unique case (state_q)
			pfb_pkg::ST_CLEAR: clr_en = 1'b1;
			pfb_pkg::ST_IDLE:  in_stall = 1'b0;
			pfb_pkg::ST_DRAW: begin
				req.valid = 1'b1;
				req.wr    = 1'b1;
			end
			pfb_pkg::ST_READ: req.valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfb_pkg::ST_CLEAR;
			clr_cnt_q   <= '0;
			clr_res_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pfb_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end else begin
				clr_cnt_q <= '0;
			end
			if (in_acc) begin
				clr_res_q <= 1'b1;
			end
			if (state_q == pfb_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (~out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q   <= command;
			x_q     <= x_pos;
			y_q     <= y_pos;
			w_q     <= rect_width;
			h_q     <= rect_height;
			color_q <= draw_color;
			res_q   <= 3'd0;
		end
		if (state_q == pfb_pkg::ST_SETUP) begin
			x0_q <= pfb_pkg::COL_W'(clamp_crd(xs, pfb_pkg::X_MAX));
			x1_q <= pfb_pkg::COL_W'(clamp_crd(xe, pfb_pkg::X_MAX));
			y0_q <= pfb_pkg::ROW_W'(clamp_crd(ys, pfb_pkg::Y_MAX));
			y1_q <= pfb_pkg::ROW_W'(clamp_crd(ye, pfb_pkg::Y_MAX));
		end
		if (state_q == pfb_pkg::ST_BASE) begin
			col_q   <= x0_q;
			row_q   <= y0_q;
			p_q     <= base;
			rbase_q <= base;
		end
		if (state_q == pfb_pkg::ST_DRAW) begin
			if (row_end) begin
				col_q   <= x0_q;
				row_q   <= row_q + 1'b1;
				rbase_q <= rbase_q + pfb_pkg::PIX_W'(pfb_pkg::SCREEN_WIDTH);
				p_q     <= rbase_q + pfb_pkg::PIX_W'(pfb_pkg::SCREEN_WIDTH);
			end else begin
				col_q <= col_q + 1'b1;
				p_q   <= p_q + 1'b1;
			end
		end
		if (state_q == pfb_pkg::ST_DRAIN && cmd_q == pfb_pkg::CMD_READ) begin
			res_q <= pix;
		end
		if (state_q == pfb_pkg::ST_DONE && out_free) begin
			out_pix_q <= res_q;
		end
	end

	pfb_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.clr_en   (clr_en),
		.clr_addr (clr_cnt_q),
		.pix      (pix)
	);

	assign out_valid   = out_valid_q;
	assign pixel_color = out_pix_q;

endmodule
